// ===== rtl/bkhh_pkg.sv =====
`default_nettype none
package bkhh_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = 11;
    localparam int NODE_W  = CNT_W + 1;
    localparam int HASH_W  = 64;
    localparam int ID_W    = 31;
    localparam int FREQ_W  = 16;

    localparam logic [CNT_W-1:0]  CAP_MIN  = CNT_W'(2);
    localparam logic [CNT_W-1:0]  CAP_MAX  = CNT_W'(DEPTH);
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [HASH_W-1:0] new_hash;
        logic [ID_W-1:0]   new_id;
        logic [FREQ_W-1:0] new_freq;
    } t_in_beat;

    typedef struct packed {
        logic [HASH_W-1:0] out_hash;
        logic [ID_W-1:0]   out_id;
        logic [FREQ_W-1:0] out_freq;
        logic [HASH_W-1:0] top_hash;
        logic [CNT_W-1:0]  fill_count;
        logic              was_duplicate;
        logic              was_kept;
        logic              was_empty;
    } t_out_beat;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [ID_W-1:0]   id;
        logic [FREQ_W-1:0] freq;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_POP_RD,
        S_POP_ROOT,
        S_POP_LAST,
        S_SD_RDL,
        S_SD_RDR,
        S_SD_CMP,
        S_SU_RD,
        S_SU_CMP,
        S_TOP_RD,
        S_TOP_CAP
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/bkhh_ram.sv =====
`default_nettype none
module bkhh_ram
    import bkhh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write one entry, read one entry registered
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/bottom_k_hash_heap_with_counts.sv =====
`default_nettype none
// Bottom-k hash keeper: a bounded max-heap of (hash, id, count) entries in one
// 1024-entry single-write, single-read RAM, run by a small sequencer that does
// one RAM read per step. An item is taken only while the block is idle. An
// insert first scans entries 1..fill one by one (stopping at an equal hash),
// then sifts up into a free slot or, if the heap is full and the hash is below
// the root's, replaces the root and sifts down; a pop reads the root and the
// last entry, then sifts down. Every item ends with a root read for top_hash.
// The RAM needs no clearing pass after reset.
// A result waits in an output register, so the next item can be taken while
// it is still stalled.
module bottom_k_hash_heap_with_counts
    import bkhh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_beat         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_beat             o_out_data
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_cap;
    logic [NODE_W-1:0] r_node, n_node;
    t_entry            r_item, n_item;
    t_entry            r_val, n_val;
    t_entry            r_left, n_left;
    t_entry            r_pop, n_pop;
    logic              r_has_l, n_has_l;
    logic              r_has_r, n_has_r;
    logic              r_dup, n_dup;
    logic              r_kept, n_kept;
    logic              r_empty, n_empty;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    t_ram_req          ram_req;
    t_entry            rdata;
    logic [CNT_W-1:0]  eff_cap;
    logic [NODE_W-1:0] kid;
    logic [HASH_W-1:0] best_hash;
    logic [1:0]        best_sel;

    bkhh_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    // clamp capacity into its legal range
    always_comb begin
        eff_cap = r_cap;
        if (r_cap < CAP_MIN) eff_cap = CAP_MIN;
        if (r_cap > CAP_MAX) eff_cap = CAP_MAX;
    end

    assign kid = {r_node[NODE_W-2:0], 1'b0};

    // pick the largest of hole value, left and right child; left first
    always_comb begin
        best_hash = r_val.hash;
        best_sel  = 2'd0;
        if (r_has_l && best_hash < r_left.hash) begin
            best_hash = r_left.hash;
            best_sel  = 2'd1;
        end
        if (r_has_r && best_hash < rdata.hash) begin
            best_sel  = 2'd2;
        end
    end

    // sequencer: next state, RAM requests and result fields
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_node      = r_node;
        n_item      = r_item;
        n_val       = r_val;
        n_left      = r_left;
        n_pop       = r_pop;
        n_has_l     = r_has_l;
        n_has_r     = r_has_r;
        n_dup       = r_dup;
        n_kept      = r_kept;
        n_empty     = r_empty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_req     = '0;
        o_in_stall  = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item.hash = i_in_data.new_hash;
                    n_item.id   = i_in_data.new_id;
                    n_item.freq = i_in_data.new_freq;
                    n_pop       = '0;
                    n_dup       = 1'b0;
                    n_kept      = 1'b0;
                    n_empty     = 1'b0;
                    n_node      = NODE_W'(1);
                    if (i_in_data.cmd == CMD_POP) begin
                        if (r_cnt == '0) begin
                            n_empty = 1'b1;
                            n_state = S_TOP_RD;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_node > {1'b0, r_cnt}) begin
                    if (r_cnt >= eff_cap) begin
                        n_state = (r_cnt != '0) ? S_ROOT_RD : S_TOP_RD;
                    end else begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_node  = {1'b0, r_cnt} + NODE_W'(1);
                        n_val   = r_item;
                        n_kept  = 1'b1;
                        n_state = S_SU_RD;
                    end
                end else begin
                    ram_req.raddr = ADDR_W'(r_node - NODE_W'(1));
                    n_state       = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rdata.hash == r_item.hash) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ADDR_W'(r_node - NODE_W'(1));
                    ram_req.wdata = rdata;
                    if (rdata.freq != FREQ_MAX) begin
                        ram_req.wdata.freq = rdata.freq + FREQ_W'(1);
                    end
                    n_dup   = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_node  = r_node + NODE_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_ROOT_RD: begin
                n_state = S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                if (r_item.hash < rdata.hash) begin
                    n_val   = r_item;
                    n_node  = NODE_W'(1);
                    n_kept  = 1'b1;
                    n_state = S_SD_RDL;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_ROOT;
            end
            S_POP_ROOT: begin
                n_pop = rdata;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt > CNT_W'(1)) begin
                    ram_req.raddr = ADDR_W'(r_cnt - CNT_W'(1));
                    n_state       = S_POP_LAST;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_POP_LAST: begin
                n_val   = rdata;
                n_node  = NODE_W'(1);
                n_state = S_SD_RDL;
            end
            S_SD_RDL: begin
                n_has_l       = (kid <= {1'b0, r_cnt});
                ram_req.raddr = ADDR_W'(kid - NODE_W'(1));
                n_state       = S_SD_RDR;
            end
            S_SD_RDR: begin
                n_left        = rdata;
                n_has_r       = (kid < {1'b0, r_cnt});
                ram_req.raddr = ADDR_W'(kid);
                n_state       = S_SD_CMP;
            end
            S_SD_CMP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(r_node - NODE_W'(1));
                case (best_sel)
                    2'd1: begin
                        ram_req.wdata = r_left;
                        n_node        = kid;
                        n_state       = S_SD_RDL;
                    end
                    2'd2: begin
                        ram_req.wdata = rdata;
                        n_node        = kid + NODE_W'(1);
                        n_state       = S_SD_RDL;
                    end
                    default: begin
                        ram_req.wdata = r_val;
                        n_state       = S_TOP_RD;
                    end
                endcase
            end
            S_SU_RD: begin
                if (r_node == NODE_W'(1)) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = '0;
                    ram_req.wdata = r_val;
                    n_state       = S_TOP_RD;
                end else begin
                    ram_req.raddr = ADDR_W'((r_node >> 1) - NODE_W'(1));
                    n_state       = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(r_node - NODE_W'(1));
                if (rdata.hash < r_val.hash) begin
                    ram_req.wdata = rdata;
                    n_node        = r_node >> 1;
                    n_state       = S_SU_RD;
                end else begin
                    ram_req.wdata = r_val;
                    n_state       = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                n_state = S_TOP_CAP;
            end
            S_TOP_CAP: begin
                // hold the result until the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_hash      = r_pop.hash;
                    n_out.out_id        = r_pop.id;
                    n_out.out_freq      = r_pop.freq;
                    n_out.top_hash      = (r_cnt != '0) ? rdata.hash : '0;
                    n_out.fill_count    = r_cnt;
                    n_out.was_duplicate = r_dup;
                    n_out.was_kept      = r_kept;
                    n_out.was_empty     = r_empty;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cap       <= CAP_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_item  <= n_item;
        r_val   <= n_val;
        r_left  <= n_left;
        r_pop   <= n_pop;
        r_has_l <= n_has_l;
        r_has_r <= n_has_r;
        r_dup   <= n_dup;
        r_kept  <= n_kept;
        r_empty <= n_empty;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/bkhh_checker.sv =====
`default_nettype none
module bkhh_checker
    import bkhh_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // an item is never both a duplicate bump and a new entry
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.was_duplicate && o_out_data.was_kept))
        else $error("duplicate and kept both set");

    // an empty pop returns zeros on an empty heap
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.was_empty |->
            o_out_data.fill_count == '0 && o_out_data.out_hash == '0 &&
            o_out_data.top_hash == '0 && !o_out_data.was_kept)
        else $error("empty pop with entries");

    // fill never exceeds storage
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.fill_count <= CAP_MAX)
        else $error("fill count past depth");

endmodule

bind bottom_k_hash_heap_with_counts bkhh_checker u_bkhh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
    import bkhh_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_beat         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_beat        o_out_data;

    bottom_k_hash_heap_with_counts dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Heap mirror, 1-based like the hardware
    logic [HASH_W-1:0] heap_hash [1:DEPTH];
    logic [ID_W-1:0]   heap_id   [1:DEPTH];
    logic [FREQ_W-1:0] heap_freq [1:DEPTH];
    int unsigned       heap_fill;
    logic [CNT_W-1:0]  cap_reg;

    t_in_beat  pending_beats[$];
    t_out_beat expected_beats[$];
    int        mismatches;
    int        out_beats;
    int        idle_cycles;
    bit        hold_off_req;
    bit        stim_done;

    localparam int WATCHDOG = 200000;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic [HASH_W-1:0] h;
        logic [ID_W-1:0]   d;
        logic [FREQ_W-1:0] f;
        h = heap_hash[a]; d = heap_id[a]; f = heap_freq[a];
        heap_hash[a] = heap_hash[b]; heap_id[a] = heap_id[b]; heap_freq[a] = heap_freq[b];
        heap_hash[b] = h; heap_id[b] = d; heap_freq[b] = f;
    endfunction

    function automatic bit bump_dup(input logic [HASH_W-1:0] h, input int unsigned node);
        if (node == 0 || node > heap_fill) return 0;
        if (heap_hash[node] == h) begin
            if (heap_freq[node] != FREQ_MAX) heap_freq[node] = heap_freq[node] + 1'b1;
            return 1;
        end
        if (h > heap_hash[node]) return 0;
        if (bump_dup(h, 2 * node)) return 1;
        return bump_dup(h, 2 * node + 1);
    endfunction

    function automatic void sink_root(input int unsigned start);
        int unsigned node, best, kid;
        node = start;
        forever begin
            best = node;
            kid = 2 * node;
            if (kid <= heap_fill && heap_hash[best] < heap_hash[kid]) best = kid;
            if (kid + 1 <= heap_fill && heap_hash[best] < heap_hash[kid + 1]) best = kid + 1;
            if (best == node) return;
            swap_slots(node, best);
            node = best;
        end
    endfunction

    function automatic void raise_leaf(input int unsigned start);
        int unsigned node;
        node = start;
        while (node > 1) begin
            if (!(heap_hash[node / 2] < heap_hash[node])) return;
            swap_slots(node / 2, node);
            node = node / 2;
        end
    endfunction

    // Work out the result beat for one accepted item
    function automatic t_out_beat heap_step(input t_in_beat b);
        t_out_beat   r;
        int unsigned eff;
        r = '0;
        eff = 32'(cap_reg < CAP_MIN ? CAP_MIN : (cap_reg > CAP_MAX ? CAP_MAX : cap_reg));
        if (b.cmd == CMD_POP) begin
            if (heap_fill == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.out_hash = heap_hash[1];
                r.out_id   = heap_id[1];
                r.out_freq = heap_freq[1];
                if (heap_fill > 1) begin
                    heap_hash[1] = heap_hash[heap_fill];
                    heap_id[1]   = heap_id[heap_fill];
                    heap_freq[1] = heap_freq[heap_fill];
                end
                heap_fill--;
                sink_root(1);
            end
        end else if (bump_dup(b.new_hash, 1)) begin
            r.was_duplicate = 1'b1;
        end else if (heap_fill >= eff) begin
            if (heap_fill > 0 && b.new_hash < heap_hash[1]) begin
                heap_hash[1] = b.new_hash;
                heap_id[1]   = b.new_id;
                heap_freq[1] = b.new_freq;
                sink_root(1);
                r.was_kept = 1'b1;
            end
        end else begin
            heap_fill++;
            heap_hash[heap_fill] = b.new_hash;
            heap_id[heap_fill]   = b.new_id;
            heap_freq[heap_fill] = b.new_freq;
            raise_leaf(heap_fill);
            r.was_kept = 1'b1;
        end
        r.top_hash   = heap_fill > 0 ? heap_hash[1] : '0;
        r.fill_count = heap_fill[CNT_W-1:0];
        return r;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // Driver: present beats from the queue with random gaps
    int unsigned in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_beats.push_back(heap_step(i_in_data));
                void'(pending_beats.pop_front());
                in_gap = gap_len();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_beats[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, with one long hold-off on request
    int unsigned hold_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt = 0;
        end else if (hold_off_req && hold_cnt == 0) begin
            hold_cnt = 3000;
            hold_off_req = 1'b0;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= hold_cnt != 0;
        end else if ($urandom_range(0, 39) == 0) begin
            hold_cnt = $urandom_range(10, 40);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(0, 3) == 0 && $urandom_range(0, 1) == 0;
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beats++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %p", o_out_data);
            end else begin
                t_out_beat e;
                e = expected_beats.pop_front();
                if (o_out_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected %p, got %p", out_beats, e, o_out_data);
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || stim_done
            || pending_beats.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("bottom_k_hash_heap_with_counts: mismatch");
            $finish;
        end
    end

    function automatic t_in_beat ins_beat(input logic [HASH_W-1:0] h);
        t_in_beat b;
        b.cmd = CMD_INSERT;
        b.new_hash = h;
        b.new_id = ID_W'($urandom);
        b.new_freq = FREQ_W'($urandom);
        return b;
    endfunction

    function automatic t_in_beat pop_beat();
        t_in_beat b;
        b = '0;
        b.cmd = CMD_POP;
        b.new_hash = {$urandom, $urandom};
        return b;
    endfunction

    function automatic logic [HASH_W-1:0] rand_hash(input int unsigned span);
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return HASH_W'($urandom_range(0, span));
    endfunction

    task automatic wait_drain();
        int unsigned guard;
        guard = 0;
        while ((pending_beats.size() > 0 || expected_beats.size() > 0) && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 2000000) begin
            $display("bottom_k_hash_heap_with_counts: mismatch");
            $finish;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        cap_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase of n items over a hash span
    task automatic random_phase(input int n, input int unsigned span, input int pop_pct);
        t_in_beat b;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < pop_pct) b = pop_beat();
            else b = ins_beat(rand_hash(span));
            pending_beats.push_back(b);
        end
    endtask

    initial begin
        logic [CNT_W-1:0] caps[6];
        t_in_beat b;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        mismatches = 0;
        out_beats = 0;
        idle_cycles = 0;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        heap_fill = 0;
        cap_reg = CAP_MAX;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, extremes, duplicates, saturation, full heap
        write_cap(CNT_W'(0));
        pending_beats.push_back(pop_beat());
        b = ins_beat('1); b.new_id = '1; b.new_freq = FREQ_MAX;
        pending_beats.push_back(b);
        pending_beats.push_back(ins_beat('1));
        b = ins_beat('0); b.new_id = '0; b.new_freq = '0;
        pending_beats.push_back(b);
        pending_beats.push_back(ins_beat(64'd5));
        pending_beats.push_back(ins_beat('1));
        pending_beats.push_back(ins_beat(64'd3));
        pending_beats.push_back(ins_beat('0));
        pending_beats.push_back(pop_beat());
        pending_beats.push_back(pop_beat());
        pending_beats.push_back(pop_beat());
        wait_drain();
        write_cap(CNT_W'(4));
        for (int k = 0; k < 6; k++) pending_beats.push_back(ins_beat(64'(100 - k * 10)));
        pending_beats.push_back(ins_beat(64'd200));
        wait_drain();
        write_cap(CNT_W'(2));
        pending_beats.push_back(ins_beat(64'd1));
        pending_beats.push_back(pop_beat());
        wait_drain();

        // Random phases across several capacities
        caps = '{CNT_W'(2047), CNT_W'(8), CNT_W'(1), CNT_W'(1024), CNT_W'(33), CNT_W'(300)};
        for (int p = 0; p < 6; p++) begin
            write_cap(caps[p]);
            if (p == 3) begin
                hold_off_req = 1'b1;
                random_phase(250, 4000, 10);
            end else begin
                random_phase(200, p == 1 ? 30 : 400, 25);
            end
            wait_drain();
        end
        // Pop 60 entries off the heap
        random_phase(60, 50, 100);
        wait_drain();

        stim_done = 1'b1;
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("bottom_k_hash_heap_with_counts: match");
        else
            $display("bottom_k_hash_heap_with_counts: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== bottom_k_hash_heap_with_counts.f =====
rtl/bkhh_pkg.sv
rtl/bkhh_ram.sv
rtl/bottom_k_hash_heap_with_counts.sv
rtl/bkhh_checker.sv
dv/tb_top.sv
